[rtl/core/isl_pkg.sv]
// Shared types and constants for the interpolated speed lookup.
// Action and status codes, field widths and the divider request bundle.
// No dependencies.
package isl_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned ActW          = 2;
  localparam int unsigned PosW          = 17;
  localparam int unsigned SpdW          = 16;
  localparam int unsigned StW           = 2;
  localparam int unsigned FracW         = 16;
  localparam int unsigned WordW         = PosW + SpdW;

  typedef enum logic [ActW-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ORDER = 2'd3
  } status_e;

  typedef struct packed {
    logic            start;
    logic [PosW-1:0] num;
    logic [PosW-1:0] den;
  } div_req_t;

endpackage

[rtl/core/isl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module isl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/isl_div.sv]
// Restoring divider for the interpolation ratio: floor(num * 2^FracW / den),
// num <= den, one quotient bit per cycle. Depends on isl_pkg.
module isl_div
  import isl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_req_t        req_i,
  output logic            done_o,
  output logic [PosW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(FracW + 1);

  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PosW:0]   rem_q, rem_d;
  logic [PosW-1:0] quot_q, quot_d;
  logic [PosW-1:0] den_q, den_d;
  logic [PosW:0]   rem_sh;
  logic [PosW:0]   den_ext;

  assign rem_sh  = {rem_q[PosW-1:0], 1'b0};
  assign den_ext = {1'b0, den_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    den_d  = den_q;
    if (req_i.start) begin
      den_d = req_i.den;
      run_d = 1'b1;
      cnt_d = CntW'(FracW);
      if (req_i.num >= req_i.den) begin
        rem_d  = {1'b0, req_i.num - req_i.den};
        quot_d = PosW'(1);
      end else begin
        rem_d  = {1'b0, req_i.num};
        quot_d = '0;
      end
    end else if (run_q) begin
      if (rem_sh >= den_ext) begin
        rem_d  = rem_sh - den_ext;
        quot_d = {quot_q[PosW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        quot_d = {quot_q[PosW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[rtl/core/interpolated_speed_lookup_top.sv]
// Channel  | Signals                                  | Handshake
// command  | action_i, position_i, speed_in_i         | start high, busy low at the edge
// result   | speed_out_o, status_o                    | done_o high for one cycle
//
// Clear, append, unused actions and a query of an empty table show their beat
// in the cycle after acceptance, and busy stays low.
// A query runs a binary search over the single RAM read port and, when it falls
// between two entries, the 17-step divider.
// Reset empties the table at once; no clearing pass. The receiver cannot stall.
// Depends on isl_pkg, isl_ram and isl_div.
module interpolated_speed_lookup_top
  import isl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [ActW-1:0] action_i,
  input  logic [PosW-1:0] position_i,
  input  logic [SpdW-1:0] speed_in_i,
  output logic            done_o,
  output logic [SpdW-1:0] speed_out_o,
  output logic [StW-1:0]  status_o
);

  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned PrW = 2 * PosW + 1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SEARCH = 9'b000000010,
    S_SWAIT  = 9'b000000100,
    S_FETCH0 = 9'b000001000,
    S_FETCH1 = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_MUL    = 9'b001000000,
    S_FIN    = 9'b010000000,
    S_LAST   = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   lo_q, lo_d;
  logic [CW-1:0]   hi_q, hi_d;
  logic [CW-1:0]   mid_q, mid_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] last_key_q, last_key_d;
  logic [PosW-1:0] x0_q, x0_d;
  logic [SpdW-1:0] s0_q, s0_d;
  logic [SpdW:0]   diff_q, diff_d;
  logic [PrW-1:0]  prod_q, prod_d;
  logic            done_q, done_d;
  logic [SpdW-1:0] speed_q, speed_d;
  status_e         status_q, status_d;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  logic [WordW-1:0] rdata;
  logic [PosW-1:0] rd_key;
  logic [SpdW-1:0] rd_spd;
  logic [CW-1:0]   mid_c;
  logic [CW-1:0]   last_c;
  logic [CW-1:0]   prev_c;
  div_req_t        div_req;
  logic            div_done;
  logic [PosW-1:0] ratio;

  assign rd_key = rdata[WordW-1 -: PosW];
  assign rd_spd = rdata[SpdW-1:0];
  assign mid_c  = lo_q + ((hi_q - lo_q) >> 1);
  assign last_c = count_q - 1'b1;
  assign prev_c = lo_q - 1'b1;
  assign waddr  = count_q[AW-1:0];

  isl_ram #(
    .Width (WordW),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({position_i, speed_in_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  isl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (ratio)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    pos_d      = pos_q;
    last_key_d = last_key_q;
    x0_d       = x0_q;
    s0_d       = s0_q;
    diff_d     = diff_q;
    prod_d     = prod_q;
    done_d     = 1'b0;
    speed_d    = speed_q;
    status_d   = status_q;
    we         = 1'b0;
    raddr      = mid_c[AW-1:0];
    div_req    = '{start: 1'b0, num: position_i, den: position_i};

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          done_d   = 1'b1;
          speed_d  = '0;
          status_d = ST_OK;
          unique case (action_i)
            ACT_CLEAR: begin
              count_d = '0;
            end
            ACT_APPEND: begin
              if (count_q == CW'(TABLE_DEPTH)) begin
                status_d = ST_FULL;
              end else if (count_q != '0 && position_i <= last_key_q) begin
                status_d = ST_ORDER;
              end else begin
                we         = 1'b1;
                count_d    = count_q + 1'b1;
                last_key_d = position_i;
              end
            end
            ACT_QUERY: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                done_d  = 1'b0;
                pos_d   = position_i;
                lo_d    = '0;
                hi_d    = count_q;
                state_d = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_c;
          raddr   = mid_c[AW-1:0];
          state_d = S_SWAIT;
        end else if (lo_q == count_q) begin
          raddr   = last_c[AW-1:0];
          state_d = S_LAST;
        end else if (lo_q == '0) begin
          raddr   = '0;
          state_d = S_LAST;
        end else begin
          raddr   = prev_c[AW-1:0];
          state_d = S_FETCH0;
        end
      end
      S_SWAIT: begin
        if (rd_key < pos_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        state_d = S_SEARCH;
      end
      S_FETCH0: begin
        x0_d    = rd_key;
        s0_d    = rd_spd;
        raddr   = lo_q[AW-1:0];
        state_d = S_FETCH1;
      end
      S_FETCH1: begin
        diff_d  = {1'b0, rd_spd} - {1'b0, s0_q};
        div_req = '{start: 1'b1, num: pos_q - x0_q, den: rd_key - x0_q};
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          prod_d  = PrW'($signed(diff_q) * $signed({1'b0, ratio}));
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        done_d   = 1'b1;
        speed_d  = s0_q + prod_q[FracW +: SpdW];
        status_d = ST_OK;
        state_d  = S_IDLE;
      end
      S_LAST: begin
        done_d   = 1'b1;
        speed_d  = rd_spd;
        status_d = ST_OK;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    pos_q      <= pos_d;
    last_key_q <= last_key_d;
    x0_q       <= x0_d;
    s0_q       <= s0_d;
    diff_q     <= diff_d;
    prod_q     <= prod_d;
    speed_q    <= speed_d;
    status_q   <= status_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign speed_out_o = speed_q;
  assign status_o    = status_q;

endmodule

[rtl/core/isl_chk.sv]
// Port-level checker for interpolated_speed_lookup_top, bound to every instance.
// Depends on isl_pkg.
module isl_chk
  import isl_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic [ActW-1:0] action_i,
  input logic            done_o,
  input logic [SpdW-1:0] speed_out_o,
  input logic [StW-1:0]  status_o
);

  logic accept;
  assign accept = start && !busy;

  a_short_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i != ACT_QUERY |=> done_o && !busy)
    else $error("short action gave no beat in the next cycle");

  a_query_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i == ACT_QUERY |=> busy || (done_o && status_o == ST_EMPTY))
    else $error("query neither started nor flagged empty");

  a_query_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o && status_o == ST_OK)
    else $error("query finished without a result beat");

  a_no_beat_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !done_o)
    else $error("beat shown while a query starts");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> speed_out_o == '0)
    else $error("error beat carries a nonzero speed");

endmodule

bind interpolated_speed_lookup_top isl_chk u_isl_chk (.*);

[sim/isl_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the interpolated speed lookup: samples command and result beats,
// predicts each reply from a private breakpoint table and compares field by field.
// Depends on isl_pkg.
module isl_checker
  import isl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  logic [ActW-1:0] action_i,
  input  logic [PosW-1:0] position_i,
  input  logic [SpdW-1:0] speed_in_i,
  input  logic            done_i,
  input  logic [SpdW-1:0] speed_out_i,
  input  logic [StW-1:0]  status_i,
  output int              fail_count_o,
  output int              owed_o
);

  typedef struct packed {
    logic [SpdW-1:0] speed;
    status_e         status;
  } reply_t;

  logic [PosW-1:0] bp_key   [TABLE_DEPTH];
  logic [SpdW-1:0] bp_speed [TABLE_DEPTH];
  int unsigned     bp_fill;
  reply_t          owed_replies [$];

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: %s mismatch, want %0h got %0h", $time, what, want, got);
    fail_count_o++;
  endtask

  function automatic logic [SpdW-1:0] interpolate_speed(input logic [PosW-1:0] pos);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    longint      x0;
    longint      x1;
    longint      s0;
    longint      s1;
    longint      ratio;
    longint      delta;
    lo = 0;
    hi = bp_fill;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (bp_key[mid] < pos) lo = mid + 1;
      else hi = mid;
    end
    if (lo == bp_fill) return bp_speed[bp_fill-1];
    if (lo == 0) return bp_speed[0];
    x0    = bp_key[lo-1];
    x1    = bp_key[lo];
    s0    = bp_speed[lo-1];
    s1    = bp_speed[lo];
    ratio = ((longint'(pos) - x0) << FracW) / (x1 - x0);
    delta = ((s1 - s0) * ratio) >>> FracW;
    return SpdW'(s0 + delta);
  endfunction

  task automatic predict_reply(input logic [ActW-1:0] act, input logic [PosW-1:0] pos,
                               input logic [SpdW-1:0] spd);
    reply_t r;
    r.speed  = '0;
    r.status = ST_OK;
    case (act)
      ACT_CLEAR: bp_fill = 0;
      ACT_APPEND: begin
        if (bp_fill >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (bp_fill > 0 && pos <= bp_key[bp_fill-1]) begin
          r.status = ST_ORDER;
        end else begin
          bp_key[bp_fill]   = pos;
          bp_speed[bp_fill] = spd;
          bp_fill++;
        end
      end
      ACT_QUERY: begin
        if (bp_fill == 0) r.status = ST_EMPTY;
        else r.speed = interpolate_speed(pos);
      end
      default: ;
    endcase
    owed_replies = {owed_replies, r};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      bp_fill = 0;
      owed_replies.delete();
    end else begin
      if (done_i) begin
        if (owed_replies.size() == 0) begin
          report_mismatch("unowed beat", '0, {speed_out_i, status_i});
        end else begin
          want = owed_replies.pop_front();
          if (speed_out_i !== want.speed) report_mismatch("speed_out", want.speed, speed_out_i);
          if (status_i !== want.status) report_mismatch("status", want.status, status_i);
        end
      end
      if (start_i && !busy_i) predict_reply(action_i, position_i, speed_in_i);
    end
    owed_o = owed_replies.size();
  end

endmodule

[sim/tb_interpolated_speed_lookup_top.sv]
`timescale 1ns / 1ps
// Testbench top for the interpolated speed lookup: drives directed and random
// table sessions with varying sender idling and gives the verdict.
// Depends on isl_pkg, interpolated_speed_lookup_top and isl_checker.
module tb_interpolated_speed_lookup_top;
  import isl_pkg::*;

  localparam int              ClkPeriod   = 8;
  localparam int unsigned     Depth       = TableDepthDef;
  localparam int              RandomBeats = 500;
  localparam int              DrainTail   = 64;
  localparam logic [ActW-1:0] ActUnused   = 2'd3;
  localparam logic [PosW-1:0] PosMax      = '1;
  localparam logic [SpdW-1:0] SpdMax      = '1;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic [ActW-1:0] action_i;
  logic [PosW-1:0] position_i;
  logic [SpdW-1:0] speed_in_i;
  logic            done_o;
  logic [SpdW-1:0] speed_out_o;
  logic [StW-1:0]  status_o;
  int              mismatches;
  int              owed;
  int              idle_pct;
  int              beats;

  interpolated_speed_lookup_top #(
    .TABLE_DEPTH(Depth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .action_i   (action_i),
    .position_i (position_i),
    .speed_in_i (speed_in_i),
    .done_o     (done_o),
    .speed_out_o(speed_out_o),
    .status_o   (status_o)
  );

  isl_checker #(
    .TABLE_DEPTH(Depth)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .action_i    (action_i),
    .position_i  (position_i),
    .speed_in_i  (speed_in_i),
    .done_i      (done_o),
    .speed_out_i (speed_out_o),
    .status_i    (status_o),
    .fail_count_o(mismatches),
    .owed_o      (owed)
  );

  always begin
    clk_i = 1'b0;
    #(ClkPeriod / 2);
    clk_i = 1'b1;
    #(ClkPeriod / 2);
  end

  task automatic send_beat(input logic [ActW-1:0] act, input logic [PosW-1:0] pos,
                           input logic [SpdW-1:0] spd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    speed_in_i <= spd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (act != ActUnused) beats++;
  endtask

  function automatic logic [SpdW-1:0] rand_speed();
    case ($urandom_range(9))
      0: return '0;
      1: return SpdMax;
      default: return SpdW'($urandom);
    endcase
  endfunction

  function automatic logic [PosW-1:0] rand_pos();
    case ($urandom_range(7))
      0: return '0;
      1: return PosMax;
      2: return PosW'(65536);
      default: return PosW'($urandom);
    endcase
  endfunction

  task automatic table_session();
    logic [PosW-1:0] keys [$];
    logic [PosW-1:0] pos;
    logic [PosW-1:0] last;
    int unsigned     key;
    int unsigned     n;
    int unsigned     pick;
    int unsigned     step;
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    send_beat(ACT_CLEAR, rand_pos(), rand_speed());
    key = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 20000);
    for (int i = 0; i < n && key <= PosMax; i++) begin
      send_beat(ACT_APPEND, PosW'(key), rand_speed());
      keys = {keys, PosW'(key)};
      if ($urandom_range(9) == 0) send_beat(ACT_APPEND, PosW'($urandom_range(0, key)), rand_speed());
      case ($urandom_range(3))
        0: step = 1;
        1: step = $urandom_range(2, 64);
        2: step = $urandom_range(65, 4000);
        default: step = $urandom_range(4001, 40000);
      endcase
      key += step;
    end
    last = keys[keys.size()-1];
    repeat ($urandom_range(2, 12)) begin
      pick = $urandom_range(keys.size() - 1);
      case ($urandom_range(7))
        0: pos = keys[pick];
        1: pos = keys[pick] + 1'b1;
        2: pos = keys[pick] - 1'b1;
        3: pos = PosW'($urandom_range(0, keys[0]));
        4: pos = PosW'($urandom_range(last, PosMax));
        5: pos = rand_pos();
        default: pos = PosW'($urandom_range(keys[0], last));
      endcase
      if ($urandom_range(11) == 0) send_beat(ActUnused, PosW'($urandom), SpdW'($urandom));
      send_beat(ACT_QUERY, pos, rand_speed());
    end
    if ($urandom_range(4) == 0) begin
      send_beat(ACT_CLEAR, '0, '0);
      send_beat(ACT_QUERY, rand_pos(), rand_speed());
    end
  endtask

  initial begin
    int target;
    rst_ni     = 1'b0;
    start      = 1'b0;
    action_i   = ACT_CLEAR;
    position_i = '0;
    speed_in_i = '0;
    idle_pct   = 0;
    beats      = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(ACT_QUERY, PosMax, SpdMax);
    send_beat(ActUnused, PosMax, SpdMax);
    send_beat(ACT_APPEND, '0, '0);
    send_beat(ACT_APPEND, '0, SpdMax);
    send_beat(ACT_APPEND, PosMax, SpdMax);
    send_beat(ACT_APPEND, PosMax - 1'b1, SpdMax);
    send_beat(ACT_QUERY, '0, '0);
    send_beat(ACT_QUERY, PosW'(1), '0);
    send_beat(ACT_QUERY, PosW'(65536), '0);
    send_beat(ACT_QUERY, PosMax, '0);
    send_beat(ActUnused, '0, '0);
    send_beat(ACT_CLEAR, PosMax, SpdMax);
    send_beat(ACT_QUERY, '0, '0);
    send_beat(ACT_APPEND, PosW'(10), SpdMax);
    send_beat(ACT_APPEND, PosW'(20), '0);
    send_beat(ACT_APPEND, PosW'(65537), SpdW'(300));
    send_beat(ACT_QUERY, PosW'(5), '0);
    send_beat(ACT_QUERY, PosW'(11), '0);
    send_beat(ACT_QUERY, PosW'(15), '0);
    send_beat(ACT_QUERY, PosW'(19), '0);
    send_beat(ACT_QUERY, PosW'(20), '0);
    send_beat(ACT_QUERY, PosW'(40000), '0);
    send_beat(ACT_QUERY, PosMax, '0);

    target = beats + RandomBeats;
    for (int s = 0; beats < target; s++) begin
      case ((s / 6) % 4)
        1: idle_pct = 63;
        3: idle_pct = 9;
        default: idle_pct = 0;
      endcase
      table_session();
    end

    start <= 1'b0;
    @(posedge clk_i);
    for (int w = 0; w < 4096 && owed != 0; w++) @(posedge clk_i);
    repeat (DrainTail) @(posedge clk_i);
    if (mismatches == 0 && owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
